FILE: sv/ufst_pkg.sv
package ufst_pkg;

  // Fixed port widths
  localparam int NODE_W     = 6;
  localparam int COST_IN_W  = 16;
  localparam int TOTAL_W    = 32;
  localparam int COUNT_W    = 6;
  localparam int CFG_W      = 7;
  localparam int RANK_W     = 3;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Parameter defaults
  localparam int MAX_NODES_DEF  = 64;
  localparam int COST_WIDTH_DEF = 16;

  // Reset value of the node count register
  localparam logic [CFG_W-1:0] NODE_COUNT_RST = CFG_W'(64);

  // Largest rank value; ranks saturate here
  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

  // Register index, taken from the word address bits of paddr
  localparam logic [APB_ADDR_W-3:0] REG_NODE_COUNT = '0;

  // Edge sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND_A,
    ST_COMP_A,
    ST_FIND_B,
    ST_COMP_B,
    ST_LINK,
    ST_BUMP,
    ST_RESULT
  } ufst_state_t;

  // Sequencer status seen by the top level
  typedef struct packed {
    logic idle;
    logic clearing;
    logic mem_wr;
  } ufst_status_t;

endpackage

FILE: sv/ufst_mem.sv
module ufst_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 9,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_q_r;
  logic [WIDTH-1:0] fwd_data_r;
  logic             fwd_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_q_r <= mem_r[rd_addr];
  end

  // Forward a write that lands on the address being read
  always_ff @(posedge clk) begin
    fwd_r      <= wr_en && (wr_addr == rd_addr);
    fwd_data_r <= wr_data;
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_q_r;

endmodule

FILE: sv/ufst_seq.sv
module ufst_seq #(
  parameter int MAX_NODES  = 64,
  parameter int COST_WIDTH = 16,
  parameter int NW         = 6,
  parameter int NCW        = 7,
  parameter int MW         = 9
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Edge request
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ufst_pkg::NODE_W-1:0]    in_src_node,
  input  logic [ufst_pkg::NODE_W-1:0]    in_dst_node,
  input  logic [ufst_pkg::COST_IN_W-1:0] in_edge_cost,
  input  logic                           in_last_edge,
  // Result
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_accepted,
  output logic [ufst_pkg::TOTAL_W-1:0]   out_total_cost,
  output logic [ufst_pkg::COUNT_W-1:0]   out_edges_taken,
  output logic                           out_tree_done,
  // Clamped node count
  input  logic [NCW-1:0]                 n_use,
  // Parent/rank memory
  output logic                           mem_wr_en,
  output logic [NW-1:0]                  mem_wr_addr,
  output logic [MW-1:0]                  mem_wr_data,
  output logic [NW-1:0]                  mem_rd_addr,
  input  logic [MW-1:0]                  mem_rd_data,
  output ufst_pkg::ufst_status_t         status
);

  import ufst_pkg::*;

  localparam int CEW  = (COST_WIDTH < COST_IN_W) ? COST_WIDTH : COST_IN_W;
  localparam int SUMW = TOTAL_W + 1;
  localparam logic [NW-1:0] LAST_NODE = NW'(MAX_NODES - 1);

  ufst_state_t state_r, state_nxt;

  logic [NW-1:0]      clr_r, clr_nxt;
  logic [NW-1:0]      cur_r, cur_nxt;
  logic [NW-1:0]      a_r, b_r;
  logic [NW-1:0]      ra_r, ra_nxt;
  logic [NW-1:0]      rb_r, rb_nxt;
  logic [RANK_W-1:0]  rank_a_r, rank_a_nxt;
  logic [RANK_W-1:0]  rank_b_r, rank_b_nxt;
  logic [CEW-1:0]     cost_r;
  logic               last_r;
  logic               acc_r, acc_nxt;
  logic [TOTAL_W-1:0] sum_r, sum_nxt;
  logic [NW-1:0]      taken_r, taken_nxt;
  logic               done_r, done_nxt;

  logic               out_valid_r;
  logic               out_acc_r;
  logic [TOTAL_W-1:0] out_sum_r;
  logic [COUNT_W-1:0] out_taken_r;
  logic               out_done_r;

  logic [NW-1:0]      rd_par;
  logic [RANK_W-1:0]  rd_rank;
  logic [NCW-1:0]     target;
  logic               in_fire;
  logic               edge_ok;
  logic               out_free;
  logic               at_root;
  logic [SUMW-1:0]    sum_wide;
  logic [NW-1:0]      taken_inc;

  assign rd_par  = mem_rd_data[NW-1:0];
  assign rd_rank = mem_rd_data[MW-1:NW];
  assign at_root = (rd_par == cur_r);

  // Edge admission
  assign target   = n_use - NCW'(1);
  assign in_fire  = (state_r == ST_IDLE) && in_valid;
  assign edge_ok  = !done_r && (NCW'(taken_r) < target) &&
                    (NCW'(in_src_node) < n_use) && (NCW'(in_dst_node) < n_use);
  assign out_free = !out_valid_r || !out_stall;

  // Saturating total and next count
  assign sum_wide  = {1'b0, sum_r} + SUMW'(cost_r);
  assign taken_inc = taken_r + NW'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == LAST_NODE) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = edge_ok ? ST_FIND_A : ST_RESULT;
      end
      ST_FIND_A: begin
        if (at_root) state_nxt = (a_r == cur_r) ? ST_FIND_B : ST_COMP_A;
      end
      ST_COMP_A: begin
        if (rd_par == ra_r) state_nxt = ST_FIND_B;
      end
      ST_FIND_B: begin
        if (at_root) state_nxt = (b_r == cur_r) ? ST_LINK : ST_COMP_B;
      end
      ST_COMP_B: begin
        if (rd_par == rb_r) state_nxt = ST_LINK;
      end
      ST_LINK: begin
        if (ra_r != rb_r && rank_a_r == rank_b_r) state_nxt = ST_BUMP;
        else                                      state_nxt = ST_RESULT;
      end
      ST_BUMP: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_nxt = last_r ? ST_CLEAR : ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Memory accesses and handshake outputs
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = cur_r;
    mem_wr_data = {rd_rank, ra_r};
    mem_rd_addr = cur_r;
    in_stall    = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_r;
        mem_wr_data = {{RANK_W{1'b0}}, clr_r};
      end
      ST_IDLE: begin
        in_stall    = 1'b0;
        mem_rd_addr = NW'(in_src_node);
      end
      ST_FIND_A: begin
        if (!at_root)           mem_rd_addr = rd_par;
        else if (a_r == cur_r)  mem_rd_addr = b_r;
        else                    mem_rd_addr = a_r;
      end
      ST_COMP_A: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = {rd_rank, ra_r};
        mem_rd_addr = (rd_par == ra_r) ? b_r : rd_par;
      end
      ST_FIND_B: begin
        if (!at_root) mem_rd_addr = rd_par;
        else          mem_rd_addr = b_r;
      end
      ST_COMP_B: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = {rd_rank, rb_r};
        mem_rd_addr = rd_par;
      end
      ST_LINK: begin
        // Hang the lower-ranked root under the other one
        mem_wr_en = (ra_r != rb_r);
        if (rank_a_r < rank_b_r) begin
          mem_wr_addr = ra_r;
          mem_wr_data = {rank_a_r, rb_r};
        end else begin
          mem_wr_addr = rb_r;
          mem_wr_data = {rank_b_r, ra_r};
        end
      end
      ST_BUMP: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ra_r;
        mem_wr_data = {(rank_a_r == RANK_MAX) ? rank_a_r : rank_a_r + RANK_W'(1), ra_r};
      end
      ST_RESULT: begin
        mem_wr_en = 1'b0;
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  assign status.idle     = (state_r == ST_IDLE);
  assign status.clearing = (state_r == ST_CLEAR);
  assign status.mem_wr   = mem_wr_en;

  // Datapath next values
  always_comb begin
    clr_nxt    = clr_r;
    cur_nxt    = cur_r;
    ra_nxt     = ra_r;
    rb_nxt     = rb_r;
    rank_a_nxt = rank_a_r;
    rank_b_nxt = rank_b_r;
    acc_nxt    = acc_r;
    sum_nxt    = sum_r;
    taken_nxt  = taken_r;
    done_nxt   = done_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = (clr_r == LAST_NODE) ? '0 : clr_r + NW'(1);
      end
      ST_IDLE: begin
        cur_nxt = NW'(in_src_node);
        acc_nxt = 1'b0;
      end
      ST_FIND_A: begin
        if (at_root) begin
          ra_nxt     = cur_r;
          rank_a_nxt = rd_rank;
          cur_nxt    = (a_r == cur_r) ? b_r : a_r;
        end else begin
          cur_nxt = rd_par;
        end
      end
      ST_COMP_A: begin
        cur_nxt = (rd_par == ra_r) ? b_r : rd_par;
      end
      ST_FIND_B: begin
        if (at_root) begin
          rb_nxt     = cur_r;
          rank_b_nxt = rd_rank;
          cur_nxt    = b_r;
        end else begin
          cur_nxt = rd_par;
        end
      end
      ST_COMP_B: begin
        cur_nxt = rd_par;
      end
      ST_LINK: begin
        // Count the edge and add its cost, saturating
        if (ra_r != rb_r) begin
          acc_nxt   = 1'b1;
          sum_nxt   = sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_wide[TOTAL_W-1:0];
          taken_nxt = taken_inc;
          if (NCW'(taken_inc) >= target) done_nxt = 1'b1;
        end
      end
      ST_RESULT: begin
        // Drop the graph totals after the last edge
        if (out_free && last_r) begin
          sum_nxt   = '0;
          taken_nxt = '0;
          done_nxt  = 1'b0;
        end
      end
      default: begin
        cur_nxt = cur_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      sum_r   <= '0;
      taken_r <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      sum_r   <= sum_nxt;
      taken_r <= taken_nxt;
      done_r  <= done_nxt;
    end
  end

  // Working registers of the edge in flight
  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    ra_r     <= ra_nxt;
    rb_r     <= rb_nxt;
    rank_a_r <= rank_a_nxt;
    rank_b_r <= rank_b_nxt;
    acc_r    <= acc_nxt;
    if (in_fire) begin
      a_r    <= NW'(in_src_node);
      b_r    <= NW'(in_dst_node);
      cost_r <= CEW'(in_edge_cost);
      last_r <= in_last_edge;
    end
  end

  // Output register: hold until the result is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_RESULT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RESULT && out_free) begin
      out_acc_r   <= acc_r;
      out_sum_r   <= sum_r;
      out_taken_r <= COUNT_W'(taken_r);
      out_done_r  <= done_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_acc_r;
  assign out_total_cost  = out_sum_r;
  assign out_edges_taken = out_taken_r;
  assign out_tree_done   = out_done_r;

endmodule

FILE: sv/union_find_spanning_tree_unit.sv
// Kruskal spanning-tree builder over a union-find forest. Feed edges in
// nondecreasing cost order, one request per edge; each request yields one
// result with the accept flag, the saturating cost total, the edge count
// and the done flag, as they stand after that edge. Parent and rank of all
// nodes live in one synchronous memory with a single read and a single
// write port. An admitted edge walks from each end node to its root and
// back, pointing the path at the root (path compression keeps it short),
// links the two roots if they differ and takes one more step when two
// equal-rank trees are joined; a request with a node out of range, or one
// arriving after the tree is done, goes straight to the result. After
// reset and after each edge marked last, a clearing pass rewrites the
// memory to singleton sets; no request is taken during it. node_count
// must be written through the register port only while no edge is in
// flight; the block does not enforce it, nor clear it at a graph's end.
module union_find_spanning_tree_unit #(
  parameter int MAX_NODES  = ufst_pkg::MAX_NODES_DEF,
  parameter int COST_WIDTH = ufst_pkg::COST_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ufst_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ufst_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ufst_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  // Edge requests
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ufst_pkg::NODE_W-1:0]     in_src_node,
  input  logic [ufst_pkg::NODE_W-1:0]     in_dst_node,
  input  logic [ufst_pkg::COST_IN_W-1:0]  in_edge_cost,
  input  logic                            in_last_edge,
  // Results
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_accepted,
  output logic [ufst_pkg::TOTAL_W-1:0]    out_total_cost,
  output logic [ufst_pkg::COUNT_W-1:0]    out_edges_taken,
  output logic                            out_tree_done
);

  import ufst_pkg::*;

  localparam int NW   = $clog2(MAX_NODES);
  localparam int MW   = RANK_W + NW;
  localparam int NCW0 = $clog2(MAX_NODES + 1);
  localparam int NCW  = (NCW0 > CFG_W) ? NCW0 : CFG_W;

  logic [CFG_W-1:0]        node_count_r;
  logic [APB_ADDR_W-3:0]   reg_idx;
  logic                    cfg_wr;
  logic [NCW-1:0]          nc_ext;
  logic [NCW-1:0]          n_use;

  logic                    mem_wr_en;
  logic [NW-1:0]           mem_wr_addr;
  logic [MW-1:0]           mem_wr_data;
  logic [NW-1:0]           mem_rd_addr;
  logic [MW-1:0]           mem_rd_data;
  ufst_status_t            status;

  // Register decode
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else if (cfg_wr && reg_idx == REG_NODE_COUNT) begin
      node_count_r <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (reg_idx == REG_NODE_COUNT) prdata = APB_DATA_W'(node_count_r);
    else                           prdata = '0;
  end

  // Clamp the node count to 1..MAX_NODES
  assign nc_ext = NCW'(node_count_r);
  always_comb begin
    if (nc_ext == '0)                   n_use = NCW'(1);
    else if (nc_ext > NCW'(MAX_NODES))  n_use = NCW'(MAX_NODES);
    else                                n_use = nc_ext;
  end

  ufst_seq #(
    .MAX_NODES  (MAX_NODES),
    .COST_WIDTH (COST_WIDTH),
    .NW         (NW),
    .NCW        (NCW),
    .MW         (MW)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_src_node     (in_src_node),
    .in_dst_node     (in_dst_node),
    .in_edge_cost    (in_edge_cost),
    .in_last_edge    (in_last_edge),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_accepted    (out_accepted),
    .out_total_cost  (out_total_cost),
    .out_edges_taken (out_edges_taken),
    .out_tree_done   (out_tree_done),
    .n_use           (n_use),
    .mem_wr_en       (mem_wr_en),
    .mem_wr_addr     (mem_wr_addr),
    .mem_wr_data     (mem_wr_data),
    .mem_rd_addr     (mem_rd_addr),
    .mem_rd_data     (mem_rd_data),
    .status          (status)
  );

  ufst_mem #(
    .DEPTH (MAX_NODES),
    .WIDTH (MW),
    .AW    (NW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // No request is taken while the memory is being cleared
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    status.clearing |-> in_stall)
    else $error("request taken during clearing pass");

  // A taken request always starts work on the edge
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !status.idle)
    else $error("sequencer stayed idle after a request");

  // Memory writes stay inside the node range
  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    status.mem_wr |-> ({1'b0, mem_wr_addr} < (NW + 1)'(MAX_NODES)))
    else $error("memory write beyond MAX_NODES");

  // The store is never written while idle
  a_no_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    status.idle |-> !status.mem_wr)
    else $error("memory written while idle");

endmodule

FILE: sim/union_find_spanning_tree_unit_tb.sv
module union_find_spanning_tree_unit_tb;
  import ufst_pkg::*;

  localparam int NODES          = MAX_NODES_DEF;
  localparam int TOTAL_EDGES    = 970;
  localparam int SETTLE_CYCLES  = NODES + 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [APB_ADDR_W-1:0] NODE_COUNT_ADDR = {REG_NODE_COUNT, 2'b00};

  typedef struct {
    bit               joined;
    bit [TOTAL_W-1:0] total;
    bit [COUNT_W-1:0] taken;
    bit               done;
  } tree_report_t;

  // Mirror of the union-find forest; predicts one report per edge request
  class kruskal_tracker_t;
    bit [NODE_W-1:0] parent_of [NODES];
    bit [RANK_W-1:0] rank_of [NODES];
    bit [TOTAL_W-1:0] cost_total;
    int unsigned      edge_tally;
    bit               tree_complete;
    bit [CFG_W-1:0]   node_reg;
    tree_report_t     due_reports [$];
    int unsigned      errors;
    int unsigned      joins;
    int unsigned      reports_seen;

    function new();
      node_reg = NODE_COUNT_RST;
      clear_forest();
    endfunction

    function void clear_forest();
      for (int k = 0; k < NODES; k++) begin
        parent_of[k] = NODE_W'(k);
        rank_of[k]   = '0;
      end
      cost_total    = '0;
      edge_tally    = 0;
      tree_complete = 1'b0;
    endfunction

    // Clamp the register to 1..NODES
    function int unsigned live_nodes();
      if (node_reg == 0) return 1;
      if (node_reg > NODES) return NODES;
      return 32'(node_reg);
    endfunction

    // Walk to the root, then point every node on the walk at it
    function int unsigned find_root(int unsigned v);
      int unsigned r;
      int unsigned nxt;
      r = v;
      while (parent_of[r] != r) r = 32'(parent_of[r]);
      while (v != r) begin
        nxt = 32'(parent_of[v]);
        parent_of[v] = NODE_W'(r);
        v = nxt;
      end
      return r;
    endfunction

    function void take_edge(bit [NODE_W-1:0] src, bit [NODE_W-1:0] dst,
                            bit [COST_IN_W-1:0] cost, bit last);
      int unsigned  n_used;
      int unsigned  ra;
      int unsigned  rb;
      tree_report_t rep;
      n_used = live_nodes();
      rep.joined = 1'b0;
      if (!tree_complete && edge_tally < n_used - 1 && src < n_used && dst < n_used) begin
        ra = find_root(32'(src));
        rb = find_root(32'(dst));
        if (ra != rb) begin
          // Union by rank, saturating rank on a tie
          if (rank_of[ra] < rank_of[rb]) begin
            parent_of[ra] = NODE_W'(rb);
          end else if (rank_of[ra] > rank_of[rb]) begin
            parent_of[rb] = NODE_W'(ra);
          end else begin
            parent_of[rb] = NODE_W'(ra);
            if (rank_of[ra] < RANK_MAX) rank_of[ra] = rank_of[ra] + RANK_W'(1);
          end
          rep.joined = 1'b1;
          if (cost_total > 32'hFFFF_FFFF - TOTAL_W'(cost)) cost_total = '1;
          else cost_total = cost_total + TOTAL_W'(cost);
          edge_tally++;
          if (edge_tally >= n_used - 1) tree_complete = 1'b1;
        end
      end
      rep.total = cost_total;
      rep.taken = COUNT_W'(edge_tally);
      rep.done  = tree_complete;
      due_reports.push_back(rep);
      if (last) clear_forest();
    endfunction

    function void match_report(bit joined, bit [TOTAL_W-1:0] total,
                               bit [COUNT_W-1:0] taken, bit done);
      tree_report_t rep;
      if (due_reports.size() == 0) begin
        $error("result arrived with no edge request outstanding");
        errors++;
        return;
      end
      rep = due_reports.pop_front();
      reports_seen++;
      if (rep.joined) joins++;
      if (joined !== rep.joined) begin
        $error("accepted: expected %0d, got %0d", rep.joined, joined);
        errors++;
      end
      if (total !== rep.total) begin
        $error("total_cost: expected %0d, got %0d", rep.total, total);
        errors++;
      end
      if (taken !== rep.taken) begin
        $error("edges_taken: expected %0d, got %0d", rep.taken, taken);
        errors++;
      end
      if (done !== rep.done) begin
        $error("tree_done: expected %0d, got %0d", rep.done, done);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_stall;
  logic [NODE_W-1:0]     in_src_node;
  logic [NODE_W-1:0]     in_dst_node;
  logic [COST_IN_W-1:0]  in_edge_cost;
  logic                  in_last_edge;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_accepted;
  logic [TOTAL_W-1:0]    out_total_cost;
  logic [COUNT_W-1:0]    out_edges_taken;
  logic                  out_tree_done;

  kruskal_tracker_t tracker;
  int unsigned      src_idle_pct;
  int unsigned      sink_stall_pct;
  int unsigned      edges_sent;
  int unsigned      graphs_run;
  int unsigned      cfg_writes;
  int unsigned      idle_cycles;

  union_find_spanning_tree_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_src_node     (in_src_node),
    .in_dst_node     (in_dst_node),
    .in_edge_cost    (in_edge_cost),
    .in_last_edge    (in_last_edge),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_accepted    (out_accepted),
    .out_total_cost  (out_total_cost),
    .out_edges_taken (out_edges_taken),
    .out_tree_done   (out_tree_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Randomly stall the result channel
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  // Record accepted requests, check results, count quiet cycles
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      tracker.take_edge(in_src_node, in_dst_node, in_edge_cost, in_last_edge);
    if (rst_n && out_valid && !out_stall)
      tracker.match_report(out_accepted, out_total_cost, out_edges_taken, out_tree_done);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Present one edge request, with optional idle gap, and hold until taken
  task automatic send_edge(input bit [NODE_W-1:0] src, input bit [NODE_W-1:0] dst,
                           input bit [COST_IN_W-1:0] cost, input bit last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_src_node  <= src;
    in_dst_node  <= dst;
    in_edge_cost <= cost;
    in_last_edge <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    edges_sent++;
  endtask

  // Drain outstanding results, let a clearing pass finish, then write the register
  task automatic set_node_count(input bit [CFG_W-1:0] value);
    in_valid <= 1'b0;
    // Let the monitor note the last request before looking at the queue
    @(posedge clk);
    while (tracker.due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NODE_COUNT_ADDR;
    pwdata  <= {25'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.node_reg = value;
    cfg_writes++;
  endtask

  // One graph: mostly in-range ends and rising costs, with some noise
  task automatic run_graph();
    int unsigned     n;
    int unsigned     num;
    int              cost;
    bit [NODE_W-1:0] a;
    bit [NODE_W-1:0] b;
    bit              last;
    n    = tracker.live_nodes();
    num  = n + $urandom_range(0, n / 2 + 2);
    cost = ($urandom_range(0, 99) < 30) ? $urandom_range(0, 255) : $urandom_range(0, 65535);
    for (int unsigned k = 0; k < num; k++) begin
      if ($urandom_range(0, 99) < 88) begin
        a = NODE_W'($urandom_range(0, n - 1));
        b = NODE_W'($urandom_range(0, n - 1));
      end else begin
        a = NODE_W'($urandom);
        b = NODE_W'($urandom);
      end
      if ($urandom_range(0, 99) < 5) begin
        cost = $urandom_range(0, 65535);
      end else begin
        cost = cost + $urandom_range(0, 3000);
        if (cost > 65535) cost = 65535;
      end
      if (k == num - 1) last = ($urandom_range(0, 99) < 90);
      else last = ($urandom_range(0, 99) < 2);
      send_edge(a, b, COST_IN_W'(cost), last);
    end
    graphs_run++;
  endtask

  initial begin
    int unsigned pick;
    tracker        = new();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    edges_sent     = 0;
    graphs_run     = 0;
    cfg_writes     = 0;
    idle_cycles    = 0;
    rst_n          <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_valid       <= 1'b0;
    in_src_node    <= '0;
    in_dst_node    <= '0;
    in_edge_cost   <= '0;
    in_last_edge   <= 1'b0;
    out_stall      <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Full-size graph: field extremes, repeat join, self loop, end of graph
    send_edge(6'd0, 6'd63, 16'd0, 1'b0);
    send_edge(6'd63, 6'd0, 16'hFFFF, 1'b0);
    send_edge(6'd5, 6'd5, 16'd1, 1'b0);
    send_edge(6'd63, 6'd62, 16'hFFFF, 1'b0);
    send_edge(6'd42, 6'd21, 16'h5555, 1'b0);
    send_edge(6'd21, 6'd42, 16'hAAAA, 1'b1);

    // Four nodes: out-of-range ends, tree completes, edge after done
    set_node_count(7'd4);
    send_edge(6'd0, 6'd1, 16'd10, 1'b0);
    send_edge(6'd1, 6'd2, 16'd20, 1'b0);
    send_edge(6'd4, 6'd0, 16'd30, 1'b0);
    send_edge(6'd3, 6'd63, 16'd40, 1'b0);
    send_edge(6'd2, 6'd3, 16'd50, 1'b0);
    send_edge(6'd0, 6'd3, 16'd60, 1'b1);

    // Single node, and zero used as one
    set_node_count(7'd1);
    send_edge(6'd0, 6'd0, 16'd7, 1'b1);
    set_node_count(7'd0);
    send_edge(6'd0, 6'd0, 16'd9, 1'b0);
    send_edge(6'd0, 6'd1, 16'd9, 1'b1);

    // Oversized count clamps; then lower the count mid-graph past the target
    set_node_count(7'd127);
    send_edge(6'd0, 6'd63, 16'd100, 1'b0);
    send_edge(6'd1, 6'd2, 16'd200, 1'b0);
    send_edge(6'd3, 6'd4, 16'd300, 1'b0);
    set_node_count(7'd3);
    send_edge(6'd5, 6'd6, 16'd400, 1'b0);
    send_edge(6'd0, 6'd2, 16'd500, 1'b1);

    // Random graphs under three idling regimes
    while (edges_sent < TOTAL_EDGES) begin
      if (edges_sent < TOTAL_EDGES / 3) begin
        src_idle_pct   = 28;
        sink_stall_pct = 83;
      end else if (edges_sent < 2 * TOTAL_EDGES / 3) begin
        src_idle_pct   = 83;
        sink_stall_pct = 28;
      end else begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      if ($urandom_range(0, 99) < 60) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) set_node_count(CFG_W'($urandom_range(0, 1)));
        else if (pick < 7) set_node_count(CFG_W'($urandom_range(65, 127)));
        else if (pick < 13) set_node_count(CFG_W'(NODES));
        else set_node_count(CFG_W'($urandom_range(2, 12)));
      end
      run_graph();
    end

    // Drain and let the block settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d edge requests over %0d random graphs and %0d node-count writes",
             edges_sent, graphs_run, cfg_writes);
    $display("%0d results checked, %0d edges joined sets, %0d mismatches",
             tracker.reports_seen, tracker.joins, tracker.errors);
    if (tracker.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
